@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication check: antecedent then consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/dwia_pkg.sv @@
// ----------------------------------------------------------------------------
// dwia_pkg
// Operation codes and the control word that travels down the ALU pipeline.
// ----------------------------------------------------------------------------
package dwia_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ABS = 4'd1,
		OP_DIV = 4'd2,
		OP_EXT = 4'd3,
		OP_SHL = 4'd4,
		OP_MUL = 4'd5,
		OP_NEG = 4'd6,
		OP_MOD = 4'd7,
		OP_SHR = 4'd8,
		OP_SUB = 4'd9
	} op_t;

	// Per-stage control word
	typedef struct packed {
		logic valid;
		op_t  op;
		logic a_neg;
		logic q_neg;
		logic b_zero;
	} ctl_t;

endpackage

@@ src/dwia_if.sv @@
// ----------------------------------------------------------------------------
// dwia_if
// Valid/ready channels for ALU requests and responses.
// ----------------------------------------------------------------------------
interface dwia_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         operation;
	logic signed [31:0] a_high;
	logic [31:0]        a_low;
	logic signed [31:0] b_high;
	logic [31:0]        b_low;
	logic [6:0]         shift_count;
	logic signed [31:0] cell_value;

	modport source (output valid, operation, a_high, a_low, b_high, b_low,
		shift_count, cell_value, input ready);
	modport sink (input valid, operation, a_high, a_low, b_high, b_low,
		shift_count, cell_value, output ready);
endinterface

interface dwia_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_high;
	logic [31:0]        result_low;
	logic               unimplemented;

	modport source (output valid, result_high, result_low, unimplemented, input ready);
	modport sink (input valid, result_high, result_low, unimplemented, output ready);
endinterface

@@ src/dwia_front.sv @@
// ----------------------------------------------------------------------------
// dwia_front
// First pipeline stage: decode, the add, subtract, abs, negate, extend and shift
// results, partial products and operand magnitudes for the divider.
// ----------------------------------------------------------------------------
module dwia_front #(
	parameter int CW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [3:0]          operation,
	input  logic [31:0]         a_high,
	input  logic [31:0]         a_low,
	input  logic [31:0]         b_high,
	input  logic [31:0]         b_low,
	input  logic [6:0]          shift_count,
	input  logic [31:0]         cell_value,
	output dwia_pkg::ctl_t      ctl_s1,
	output logic [2*CW-1:0]     res_s1,
	output logic [2*CW-1:0]     pp0_s1,
	output logic [CW-1:0]       pp1_s1,
	output logic [CW-1:0]       pp2_s1,
	output logic [2*CW-1:0]     dvd_s1,
	output logic [2*CW-1:0]     dsr_s1
);
	localparam int LW = 2 * CW;

	logic [LW-1:0] a, b, mag_a, mag_b, res;
	logic          a_neg, b_neg;
	dwia_pkg::op_t op;
	dwia_pkg::ctl_t ctl;

	assign a     = {a_high[CW-1:0], a_low[CW-1:0]};
	assign b     = {b_high[CW-1:0], b_low[CW-1:0]};
	assign a_neg = a[LW-1];
	assign b_neg = b[LW-1];
	assign mag_a = a_neg ? (~a + LW'(1)) : a;
	assign mag_b = b_neg ? (~b + LW'(1)) : b;
	assign op    = dwia_pkg::op_t'(operation);

	// Operations done in one stage
	always_comb begin
		unique case (op)
			dwia_pkg::OP_ADD: res = a + b;
			dwia_pkg::OP_SUB: res = a - b;
			dwia_pkg::OP_ABS: res = mag_a;
			dwia_pkg::OP_NEG: res = ~a + LW'(1);
			dwia_pkg::OP_EXT: res = LW'($signed(cell_value[CW-1:0]));
			dwia_pkg::OP_SHL: res = a << shift_count;
			dwia_pkg::OP_SHR: res = $signed(a) >>> shift_count;
			default:          res = '0;
		endcase
	end

	always_comb begin
		ctl.valid  = in_valid;
		ctl.op     = op;
		ctl.a_neg  = a_neg;
		ctl.q_neg  = a_neg ^ b_neg;
		ctl.b_zero = (b == '0);
	end

	// Control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
		end
	end

	// Payload register: partial products of the low long-width product
	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= res;
			pp0_s1 <= LW'(a[CW-1:0]) * LW'(b[CW-1:0]);
			pp1_s1 <= a[CW-1:0] * b[LW-1:CW];
			pp2_s1 <= a[LW-1:CW] * b[CW-1:0];
			dvd_s1 <= mag_a;
			dsr_s1 <= mag_b;
		end
	end

endmodule

@@ src/dwia_div_step.sv @@
// ----------------------------------------------------------------------------
// dwia_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module dwia_div_step #(
	parameter int LW = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic [LW-1:0] rem_i,
	input  logic [LW-1:0] q_i,
	input  logic [LW-1:0] d_i,
	output logic [LW-1:0] rem_o,
	output logic [LW-1:0] q_o,
	output logic [LW-1:0] d_o
);
	logic [LW-1:0] trial;
	logic          fits;

	// Remainder stays below a non-zero divisor, so the shift never loses a bit
	assign trial = {rem_i[LW-2:0], q_i[LW-1]};
	assign fits  = (trial >= d_i);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= fits ? (trial - d_i) : trial;
			q_o   <= {q_i[LW-2:0], fits};
			d_o   <= d_i;
		end
	end

endmodule

@@ src/double_width_integer_alu.sv @@
// ----------------------------------------------------------------------------
// double_width_integer_alu
// Double-width integer ALU, fully pipelined with a bit-per-stage divider.
// ----------------------------------------------------------------------------
//  Channel | Dir | Fields
//  req     | in  | operation, a_high, a_low, b_high, b_low, shift_count, cell_value
//  rsp     | out | result_high, result_low, unimplemented
//
//  Requests pass front stage, divider and output register; one is taken each cycle
//  unless rsp stalls. The depth is set by the divider, one quotient bit per stage.
//  Reset clears all valid bits; payload registers are not reset.
//  A stalled response freezes the whole pipeline; req.ready drops with it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_width_integer_alu #(
	parameter int CELL_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	dwia_req_if.sink   req,
	dwia_rsp_if.source rsp
);
	localparam int CW = CELL_WIDTH;
	localparam int LW = 2 * CW;

	logic en;

	dwia_pkg::ctl_t ctl_s   [0:LW];
	logic [LW-1:0]  res_s   [0:LW];
	logic [LW-1:0]  rem_s   [0:LW];
	logic [LW-1:0]  q_s     [0:LW];
	logic [LW-1:0]  d_s     [0:LW];

	logic [LW-1:0]  pp0_s1;
	logic [CW-1:0]  pp1_s1, pp2_s1;
	logic [LW-1:0]  mul_sum;

	logic           out_valid_q;
	logic [LW-1:0]  res_q;
	logic           unimp_q;
	logic [LW-1:0]  fin_res;
	logic           fin_unimp;

	// Global advance: move when the output register is free
	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	dwia_front #(.CW(CW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (req.valid),
		.operation   (req.operation),
		.a_high      (req.a_high),
		.a_low       (req.a_low),
		.b_high      (req.b_high),
		.b_low       (req.b_low),
		.shift_count (req.shift_count),
		.cell_value  (req.cell_value),
		.ctl_s1      (ctl_s[0]),
		.res_s1      (res_s[0]),
		.pp0_s1      (pp0_s1),
		.pp1_s1      (pp1_s1),
		.pp2_s1      (pp2_s1),
		.dvd_s1      (q_s[0]),
		.dsr_s1      (d_s[0])
	);

	assign rem_s[0] = '0;
	assign mul_sum  = pp0_s1 + {pp1_s1 + pp2_s1, CW'(0)};

	// Divider chain, with control and side results travelling alongside
	for (genvar k = 0; k < LW; k++) begin : g_stage
		dwia_div_step #(.LW(LW)) u_step (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_s[k]),
			.q_i   (q_s[k]),
			.d_i   (d_s[k]),
			.rem_o (rem_s[k+1]),
			.q_o   (q_s[k+1]),
			.d_o   (d_s[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		if (k == 0) begin : g_mul
			always_ff @(posedge clk) begin
				if (en) begin
					res_s[k+1] <= (ctl_s[k].op == dwia_pkg::OP_MUL) ? mul_sum : res_s[k];
				end
			end
		end else begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					res_s[k+1] <= res_s[k];
				end
			end
		end
	end

	// Final select with sign correction of quotient and remainder; zero on a zero divisor
	always_comb begin
		fin_unimp = 1'b0;
		unique case (ctl_s[LW].op)
			dwia_pkg::OP_ADD, dwia_pkg::OP_SUB, dwia_pkg::OP_ABS, dwia_pkg::OP_NEG,
			dwia_pkg::OP_EXT, dwia_pkg::OP_SHL, dwia_pkg::OP_SHR,
			dwia_pkg::OP_MUL: fin_res = res_s[LW];
			dwia_pkg::OP_DIV: begin
				if (ctl_s[LW].b_zero) fin_res = '0;
				else if (ctl_s[LW].q_neg) fin_res = ~q_s[LW] + LW'(1);
				else fin_res = q_s[LW];
			end
			dwia_pkg::OP_MOD: begin
				if (ctl_s[LW].b_zero) fin_res = '0;
				else if (ctl_s[LW].a_neg) fin_res = ~rem_s[LW] + LW'(1);
				else fin_res = rem_s[LW];
			end
			default: begin
				fin_res   = '0;
				fin_unimp = 1'b1;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s[LW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= fin_res;
			unimp_q <= fin_unimp;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_high   = 32'($signed(res_q[LW-1:CW]));
	assign rsp.result_low    = 32'(res_q[CW-1:0]);
	assign rsp.unimplemented = unimp_q;

	// Checks
	`ASSERT_IMPL(a_unimp_zero, out_valid_q && unimp_q, res_q == '0,
		"unimplemented operation with non-zero result")
	`ASSERT_CLK(a_stall_hold, !en |=> $stable(ctl_s[LW]),
		"last divider stage moved during a stall")
	`ASSERT_CLK(a_valid_rise, $rose(out_valid_q) |-> $past(en),
		"response appeared without pipeline advance")

endmodule

@@ tb/tb_double_width_integer_alu.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_width_integer_alu
// Drives random and corner-case ALU requests through the pipeline and checks
// every response against a behavioural prediction held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_double_width_integer_alu;

	localparam int LATENCY   = 66;
	localparam int N_RANDOM  = 1180;
	localparam int MAX_CYCLE = 400000;

	// Operation codes outside the implemented set
	localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
	localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

	typedef struct {
		logic [3:0]         operation;
		logic signed [31:0] a_high;
		logic [31:0]        a_low;
		logic signed [31:0] b_high;
		logic [31:0]        b_low;
		logic [6:0]         shift_count;
		logic signed [31:0] cell_value;
	} alu_req_t;

	typedef struct {
		logic [31:0] result_high;
		logic [31:0] result_low;
		logic        unimplemented;
	} alu_rsp_t;

	logic clk;
	logic arst_n;
	int   n_errors;
	int   cycle_count;
	logic hold_off;
	logic drain_check;

	dwia_req_if req ();
	dwia_rsp_if rsp ();

	double_width_integer_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Mismatch reporting
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR @%0d: %s got %h expected %h", cycle_count, what, got, want);
		n_errors++;
	endtask

	// Result prediction for one request
	function automatic alu_rsp_t alu_predict(input alu_req_t t);
		logic [63:0]  a, b, r, ma, mb;
		logic [127:0] fill;
		alu_rsp_t     p;
		a = {t.a_high, t.a_low};
		b = {t.b_high, t.b_low};
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		r = '0;
		p.unimplemented = 1'b0;
		case (t.operation)
			dwia_pkg::OP_ADD: r = a + b;
			dwia_pkg::OP_ABS: r = ma;
			dwia_pkg::OP_DIV: if (b != 0) begin
				r = ma / mb;
				if (a[63] != b[63]) r = -r;
			end
			dwia_pkg::OP_EXT: r = {{32{t.cell_value[31]}}, t.cell_value};
			dwia_pkg::OP_SHL: r = (t.shift_count >= 64) ? 64'd0 : a << t.shift_count;
			dwia_pkg::OP_MUL: r = a * b;
			dwia_pkg::OP_NEG: r = -a;
			dwia_pkg::OP_MOD: if (b != 0) begin
				r = ma % mb;
				if (a[63]) r = -r;
			end
			dwia_pkg::OP_SHR: begin
				fill = {{64{a[63]}}, a} >> t.shift_count;
				r = (t.shift_count >= 64) ? {64{a[63]}} : fill[63:0];
			end
			dwia_pkg::OP_SUB: r = a - b;
			default: p.unimplemented = 1'b1;
		endcase
		p.result_high = r[63:32];
		p.result_low  = r[31:0];
		return p;
	endfunction

	// Scoreboard: queue of predicted responses
	class alu_scoreboard;
		alu_rsp_t pending[$];

		function void note_request(alu_req_t t);
			pending.push_back(alu_predict(t));
		endfunction

		task check_response(alu_rsp_t got);
			alu_rsp_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected transaction", got.result_low, 32'h0);
				return;
			end
			want = pending.pop_front();
			if (got.result_high !== want.result_high)
				report_mismatch("result_high", got.result_high, want.result_high);
			if (got.result_low !== want.result_low)
				report_mismatch("result_low", got.result_low, want.result_low);
			if (got.unimplemented !== want.unimplemented)
				report_mismatch("unimplemented", 32'(got.unimplemented),
					32'(want.unimplemented));
		endtask
	endclass

	alu_scoreboard sb = new();

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Short gaps mostly, occasionally a long one
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [31:0] pick_cell();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic alu_req_t random_req();
		alu_req_t t;
		t.operation   = ($urandom_range(0, 19) == 0)
			? 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED))
			: 4'($urandom_range(dwia_pkg::OP_ADD, dwia_pkg::OP_SUB));
		t.a_high      = pick_cell();
		t.a_low       = pick_cell();
		t.b_high      = pick_cell();
		t.b_low       = pick_cell();
		t.shift_count = ($urandom_range(0, 3) == 0) ? 7'($urandom)
			: 7'($urandom_range(0, 70));
		t.cell_value  = pick_cell();
		// Small signed divisor now and then
		if ($urandom_range(0, 3) == 0) begin
			t.b_low  = $urandom_range(0, 40) - 20;
			t.b_high = {32{t.b_low[31]}};
		end
		return t;
	endfunction

	function automatic alu_req_t make_req(input dwia_pkg::op_t o, input logic [63:0] a,
			input logic [63:0] b, input logic [6:0] sh, input logic [31:0] c);
		alu_req_t t;
		t.operation = o;
		{t.a_high, t.a_low} = a;
		{t.b_high, t.b_low} = b;
		t.shift_count = sh;
		t.cell_value = c;
		return t;
	endfunction

	// Send one transaction and wait for its acceptance
	task automatic send_req(input alu_req_t t);
		req.valid       <= 1'b1;
		req.operation   <= t.operation;
		req.a_high      <= t.a_high;
		req.a_low       <= t.a_low;
		req.b_high      <= t.b_high;
		req.b_low       <= t.b_low;
		req.shift_count <= t.shift_count;
		req.cell_value  <= t.cell_value;
		do @(posedge clk); while (!req.ready);
		sb.note_request(t);
	endtask

	task automatic send_with_gap(input alu_req_t t, input bit gaps);
		int g;
		send_req(t);
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Response side: sample at the edge, then set ready for the next
	initial begin
		alu_rsp_t got;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.result_high   = rsp.result_high;
				got.result_low    = rsp.result_low;
				got.unimplemented = rsp.unimplemented;
				sb.check_response(got);
			end
			rsp.ready <= !hold_off && ($urandom_range(0, 3) != 0);
		end
	end

	// Long receiver stall in its own process
	initial begin
		hold_off = 1'b0;
		wait (drain_check);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [63:0] MIN64;
		alu_req_t    t;
		MIN64 = 64'h8000_0000_0000_0000;
		drain_check = 1'b0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= '0;
		req.a_high <= '0;
		req.a_low <= '0;
		req.b_high <= '0;
		req.b_low <= '0;
		req.shift_count <= '0;
		req.cell_value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners
		send_req(make_req(dwia_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_SUB, MIN64, 64'd1, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_ABS, MIN64, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_ABS, -64'd5, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_NEG, MIN64, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_NEG, 64'd7, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_DIV, MIN64, -64'd1, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_DIV, -64'd7, 64'd2, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_DIV, 64'd7, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_MOD, -64'd7, 64'd2, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_MOD, 64'd7, -64'd3, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_MOD, 64'd7, 64'd0, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_EXT, 64'd0, 64'd0, 7'd0, 32'h8000_0000));
		send_req(make_req(dwia_pkg::OP_EXT, 64'd0, 64'd0, 7'd0, 32'h7FFF_FFFF));
		send_req(make_req(dwia_pkg::OP_SHL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 7'd63, 32'd0));
		send_req(make_req(dwia_pkg::OP_SHL, 64'd1, 64'd0, 7'd64, 32'd0));
		send_req(make_req(dwia_pkg::OP_SHL, 64'd1, 64'd0, 7'd127, 32'd0));
		send_req(make_req(dwia_pkg::OP_SHR, MIN64, 64'd0, 7'd63, 32'd0));
		send_req(make_req(dwia_pkg::OP_SHR, MIN64, 64'd0, 7'd127, 32'd0));
		send_req(make_req(dwia_pkg::OP_SHR, 64'h7FFF_0000_0000_0000, 64'd0, 7'd64, 32'd0));
		send_req(make_req(dwia_pkg::OP_MUL, MIN64, -64'd1, 7'd0, 32'd0));
		send_req(make_req(dwia_pkg::OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 32'd0));
		t = random_req();
		t.operation = OP_FIRST_UNUSED;
		send_req(t);
		t.operation = OP_LAST_UNUSED;
		send_req(t);
		wait_drained();

		// Fill the pipeline against a stalled receiver
		drain_check = 1'b1;
		for (int i = 0; i < 150; i++) send_req(random_req());
		wait_drained();

		// Random traffic with idle gaps on both sides
		for (int i = 0; i < N_RANDOM; i++) begin
			send_with_gap(random_req(), (i / 200) % 2 == 0);
			if (i == N_RANDOM / 2) wait_drained();
		end
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);

		if (n_errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
